/* hw/rtl/logistic_neuron_trainer_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the logistic neuron trainer
// Each check is written as one macro use. Defining ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef LOGISTIC_NEURON_TRAINER_TOP_ASSERT_SVH
`define LOGISTIC_NEURON_TRAINER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define LNT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lnt: same-cycle check failed");
// Implication checked in the next cycle.
`define LNT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lnt: next-cycle check failed");
`else
`define LNT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LNT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/lnt_pkg.sv */
// ----------------------------------------------------------------------------
// lnt_pkg
// Word types, codes and elaboration-time sigmoid table builder shared by the
// logistic neuron trainer.
// ----------------------------------------------------------------------------
`default_nettype none

package lnt_pkg;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] feature_one;
    logic signed [15:0] feature_two;
    logic [12:0]        target;
  } sample_t;

  typedef struct packed {
    logic [12:0]        probability;
    logic               decision;
    logic               updated;
    logic signed [31:0] weight_one_out;
    logic signed [31:0] weight_two_out;
    logic signed [31:0] bias_out;
  } result_t;

  localparam logic OP_TRAIN   = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

  localparam logic REG_STEP_SIZE  = 1'b0;
  localparam logic REG_BATCH_LOG2 = 1'b1;

  localparam int ADDR_W = 3;

  localparam logic [15:0] STEP_SIZE_RESET  = 16'd4096;
  localparam logic [2:0]  BATCH_LOG2_RESET = 3'd2;

  localparam logic [12:0] PROB_ONE  = 13'd4096;
  localparam logic [12:0] PROB_HALF = 13'd2048;

  // Score in Q.16 after the product sum has been scaled down.
  localparam int SCORE_W         = 38;
  localparam int SCORE_HALF_SPAN = 524288;

  localparam logic [63:0] Q32_ONE   = 64'h1_0000_0000;
  localparam logic [63:0] Q32_INV_E = 64'd1580030169;

  // Restoring division, only ever evaluated while the table is elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^(-a) in Q32 for a in Q16, 0 <= a < 8.
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] a);
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] term;
    logic [63:0] acc;
    whole = a >> 16;
    frac  = a & 64'hFFFF;
    term  = Q32_ONE;
    acc   = Q32_ONE;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64(term * frac, 64'd65536 * 64'(k));
      if (k[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    for (int j = 0; j < 8; j++) begin
      if (64'(j) < whole) begin
        acc = (acc * Q32_INV_E + 64'h8000_0000) >> 32;
      end
    end
    return acc;
  endfunction

  // Sigmoid at the midpoint of table bin idx, rounded to Q0.12.
  function automatic logic [12:0] sigmoid_entry(input int unsigned idx,
                                                 input int unsigned entries);
    logic [63:0]        mid;
    logic signed [63:0] x;
    logic [63:0]        s;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        val;
    mid = udiv64(64'd1048576 * 64'(2 * idx + 1), 64'(2 * entries));
    x   = $signed(mid) - 64'sd524288;
    if (x < 0) begin
      s   = exp_neg_q32(64'(-x));
      num = s;
    end else begin
      s   = exp_neg_q32(64'(x));
      num = Q32_ONE;
    end
    den = Q32_ONE + s;
    val = udiv64(num * 64'd4096 + (den >> 1), den);
    return val[12:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lnt_sigmoid_rom.sv */
// ----------------------------------------------------------------------------
// lnt_sigmoid_rom
// Maps a Q.16 score onto a sigmoid table bin and returns the registered
// probability. Scores outside [-8,8) use the first or last bin.
// ----------------------------------------------------------------------------
`default_nettype none

module lnt_sigmoid_rom #(
  parameter int ENTRIES = 256
) (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire logic signed [lnt_pkg::SCORE_W-1:0] score,
  output logic [12:0]                             probability
);

  localparam int IDXW = $clog2(ENTRIES);
  localparam int PW   = 20 + $clog2(ENTRIES + 1);
  localparam logic signed [lnt_pkg::SCORE_W-1:0] SPAN =
    lnt_pkg::SCORE_W'(lnt_pkg::SCORE_HALF_SPAN);

  logic [12:0] rom [ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
    localparam logic [12:0] ENTRY = lnt_pkg::sigmoid_entry(i, ENTRIES);
    assign rom[i] = ENTRY;
  end

  logic signed [lnt_pkg::SCORE_W-1:0] shifted;
  logic                               below;
  logic                               above;
  logic [19:0]                        offset;
  logic [PW-1:0]                      scaled;
  logic [IDXW-1:0]                    idx;

  always_comb begin
    shifted = score + SPAN;
    below   = shifted[lnt_pkg::SCORE_W-1];
    above   = !below && (|shifted[lnt_pkg::SCORE_W-2:20]);
    offset  = shifted[19:0];
    scaled  = PW'(offset) * PW'(ENTRIES);
    priority if (below) begin
      idx = '0;
    end else if (above) begin
      idx = IDXW'(ENTRIES - 1);
    end else begin
      idx = scaled[20 +: IDXW];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      probability <= rom[idx];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/logistic_neuron_trainer_top.sv */
// ----------------------------------------------------------------------------
// logistic_neuron_trainer_top
// Two-input sigmoid neuron with mini-batch gradient descent. Each word on
// the sample channel either trains (operation 0) or only predicts
// (operation 1); every word returns one result word whose probability uses
// the weights as they stood before that word, and whose weights are the
// ones after it. One shared 33x17 signed multiplier, run by a sequencer,
// does all products, so the block takes one word at a time: it accepts no
// new word until the sequencer is back in idle. A training sample also runs
// the gradient states, and a sample that closes a batch then runs the step
// states for each of the two weights and the bias. A
// finished result waits in an output register, so a new word may be
// accepted before the previous result is taken. Registers sit at byte
// address 0 (step size, unsigned Q4.12) and 4 (batch_log2).
// ----------------------------------------------------------------------------
`default_nettype none

`include "logistic_neuron_trainer_top_assert.svh"

module logistic_neuron_trainer_top #(
  parameter int SIGMOID_ENTRIES = 256,
  parameter int MAX_BATCH       = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lnt_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  wire logic                        sample_valid,
  output logic                             sample_ready,
  input  wire lnt_pkg::sample_t            sample,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output lnt_pkg::result_t                 result
);

  localparam int KMAX = $clog2(MAX_BATCH + 1) - 1;
  localparam int CNTW = KMAX + 1;
  localparam int TW   = 58;
  localparam logic [CNTW-1:0] BATCH_CAP = CNTW'(1) << KMAX;

  localparam logic [1:0] PARAM_W1   = 2'd0;
  localparam logic [1:0] PARAM_W2   = 2'd1;
  localparam logic [1:0] PARAM_BIAS = 2'd2;

  typedef enum logic [14:0] {
    ST_IDLE       = 15'b000000000000001,
    ST_FWD_ONE    = 15'b000000000000010,
    ST_FWD_TWO    = 15'b000000000000100,
    ST_FWD_SUM    = 15'b000000000001000,
    ST_SCORE      = 15'b000000000010000,
    ST_LOOKUP     = 15'b000000000100000,
    ST_GRAD_ONE   = 15'b000000001000000,
    ST_GRAD_TWO   = 15'b000000010000000,
    ST_GRAD_SUM   = 15'b000000100000000,
    ST_STEP_LO    = 15'b000001000000000,
    ST_STEP_HI    = 15'b000010000000000,
    ST_STEP_ADD   = 15'b000100000000000,
    ST_STEP_SHIFT = 15'b001000000000000,
    ST_STEP_APPLY = 15'b010000000000000,
    ST_DONE       = 15'b100000000000000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration and learned state.
  logic [15:0]        step_size;
  logic [2:0]         batch_log2;
  logic signed [31:0] first_weight;
  logic signed [31:0] second_weight;
  logic signed [31:0] bias_term;
  logic signed [39:0] first_gradient_sum;
  logic signed [39:0] second_gradient_sum;
  logic signed [39:0] bias_gradient_sum;
  logic [CNTW-1:0]    samples_in_batch;
  logic [1:0]         sel;

  // Working registers of the current word.
  logic                               op_q;
  logic signed [15:0]                 x1_q;
  logic signed [15:0]                 x2_q;
  logic [12:0]                        tgt_q;
  logic                               upd_q;
  logic signed [49:0]                 mul_q;
  logic signed [48:0]                 acc;
  logic signed [lnt_pkg::SCORE_W-1:0] score_q;
  logic signed [TW-1:0]               t_q;
  logic signed [37:0]                 delta_q;
  logic [12:0]                        prob;

  logic                               cfg_write;
  logic                               out_free;
  logic [2:0]                         k_eff;
  logic [CNTW-1:0]                    count_inc;
  logic                               batch_done;
  logic signed [13:0]                 err;
  logic signed [39:0]                 err_bias;
  logic signed [32:0]                 mul_a;
  logic signed [16:0]                 mul_b;
  logic signed [48:0]                 acc_shift;
  logic signed [lnt_pkg::SCORE_W-1:0] score_next;
  logic signed [39:0]                 sum_sel;
  logic signed [31:0]                 param_sel;
  logic signed [39:0]                 diff;
  logic signed [31:0]                 step_value;
  logic [4:0]                         shamt;
  logic signed [TW-1:0]               round_bit;
  logic signed [TW-1:0]               t_shift;

  logic                               predict_busy;
  logic                               sums_zero;
  logic [3*32+CNTW-1:0]               learned_state;

  assign pready       = 1'b1;
  assign cfg_write    = psel & penable & pwrite;
  assign sample_ready = (state == ST_IDLE);
  assign out_free     = !result_valid || result_ready;

  always_comb begin
    unique case (paddr[2])
      lnt_pkg::REG_STEP_SIZE:  prdata = {16'b0, step_size};
      lnt_pkg::REG_BATCH_LOG2: prdata = {29'b0, batch_log2};
      default:                 prdata = '0;
    endcase
  end

  // Batch size is capped at the largest power of two within MAX_BATCH.
  assign k_eff      = (batch_log2 > 3'(KMAX)) ? 3'(KMAX) : batch_log2;
  assign count_inc  = samples_in_batch + CNTW'(1);
  assign batch_done = (count_inc >= (CNTW'(1) << k_eff));

  assign err      = $signed({1'b0, prob}) - $signed({1'b0, tgt_q});
  assign err_bias = {{14{err[13]}}, err, 12'b0};

  always_comb begin
    unique case (sel)
      PARAM_W1: begin
        sum_sel   = first_gradient_sum;
        param_sel = first_weight;
      end
      PARAM_W2: begin
        sum_sel   = second_gradient_sum;
        param_sel = second_weight;
      end
      default: begin
        sum_sel   = bias_gradient_sum;
        param_sel = bias_term;
      end
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_FWD_ONE: begin
        mul_a = {first_weight[31], first_weight};
        mul_b = {x1_q[15], x1_q};
      end
      ST_FWD_TWO: begin
        mul_a = {second_weight[31], second_weight};
        mul_b = {x2_q[15], x2_q};
      end
      ST_GRAD_ONE: begin
        mul_a = {{19{err[13]}}, err};
        mul_b = {x1_q[15], x1_q};
      end
      ST_GRAD_TWO: begin
        mul_a = {{19{err[13]}}, err};
        mul_b = {x2_q[15], x2_q};
      end
      // The 40-bit sum is split into an unsigned low part and a signed high
      // part so the step product fits the shared multiplier.
      ST_STEP_LO: begin
        mul_a = {9'b0, sum_sel[23:0]};
        mul_b = {1'b0, step_size};
      end
      ST_STEP_HI: begin
        mul_a = {{17{sum_sel[39]}}, sum_sel[39:24]};
        mul_b = {1'b0, step_size};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    acc_shift  = acc >>> 12;
    score_next = $signed(acc_shift[lnt_pkg::SCORE_W-1:0]) +
                 $signed({{(lnt_pkg::SCORE_W - 32){bias_term[31]}}, bias_term});
    shamt      = 5'd20 + 5'(k_eff);
    round_bit  = TW'(1) << (5'd19 + 5'(k_eff));
    t_shift    = t_q >>> shamt;
    diff       = $signed({{8{param_sel[31]}}, param_sel}) -
                 $signed({{2{delta_q[37]}}, delta_q});
    priority if (diff[39] && !(&diff[38:31])) begin
      step_value = 32'sh8000_0000;
    end else if (!diff[39] && (|diff[38:31])) begin
      step_value = 32'sh7FFF_FFFF;
    end else begin
      step_value = diff[31:0];
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE:       state_next = sample_valid ? ST_FWD_ONE : ST_IDLE;
      ST_FWD_ONE:    state_next = ST_FWD_TWO;
      ST_FWD_TWO:    state_next = ST_FWD_SUM;
      ST_FWD_SUM:    state_next = ST_SCORE;
      ST_SCORE:      state_next = ST_LOOKUP;
      ST_LOOKUP:     state_next = (op_q == lnt_pkg::OP_TRAIN) ? ST_GRAD_ONE : ST_DONE;
      ST_GRAD_ONE:   state_next = ST_GRAD_TWO;
      ST_GRAD_TWO:   state_next = ST_GRAD_SUM;
      ST_GRAD_SUM:   state_next = batch_done ? ST_STEP_LO : ST_DONE;
      ST_STEP_LO:    state_next = ST_STEP_HI;
      ST_STEP_HI:    state_next = ST_STEP_ADD;
      ST_STEP_ADD:   state_next = ST_STEP_SHIFT;
      ST_STEP_SHIFT: state_next = ST_STEP_APPLY;
      ST_STEP_APPLY: state_next = (sel == PARAM_BIAS) ? ST_DONE : ST_STEP_LO;
      ST_DONE:       state_next = out_free ? ST_IDLE : ST_DONE;
      default:       state_next = ST_IDLE;
    endcase
  end

  lnt_sigmoid_rom #(
    .ENTRIES(SIGMOID_ENTRIES)
  ) u_rom (
    .clk        (clk),
    .load       (state == ST_LOOKUP),
    .score      (score_q),
    .probability(prob)
  );

  // Control and learned state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      step_size           <= lnt_pkg::STEP_SIZE_RESET;
      batch_log2          <= lnt_pkg::BATCH_LOG2_RESET;
      first_weight        <= '0;
      second_weight       <= '0;
      bias_term           <= '0;
      first_gradient_sum  <= '0;
      second_gradient_sum <= '0;
      bias_gradient_sum   <= '0;
      samples_in_batch    <= '0;
      sel                 <= PARAM_W1;
      result_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (paddr[2])
          lnt_pkg::REG_STEP_SIZE:  step_size  <= pwdata[15:0];
          lnt_pkg::REG_BATCH_LOG2: batch_log2 <= pwdata[2:0];
          default: ;
        endcase
      end

      if (state == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_GRAD_TWO: begin
          first_gradient_sum <= first_gradient_sum + $signed(mul_q[39:0]);
        end
        ST_GRAD_SUM: begin
          second_gradient_sum <= second_gradient_sum + $signed(mul_q[39:0]);
          bias_gradient_sum   <= bias_gradient_sum + err_bias;
          samples_in_batch    <= batch_done ? '0 : count_inc;
          sel                 <= PARAM_W1;
        end
        ST_STEP_APPLY: begin
          unique case (sel)
            PARAM_W1: begin
              first_weight       <= step_value;
              first_gradient_sum <= '0;
            end
            PARAM_W2: begin
              second_weight       <= step_value;
              second_gradient_sum <= '0;
            end
            default: begin
              bias_term         <= step_value;
              bias_gradient_sum <= '0;
            end
          endcase
          sel <= sel + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          op_q  <= sample.operation;
          x1_q  <= sample.feature_one;
          x2_q  <= sample.feature_two;
          tgt_q <= (sample.target > lnt_pkg::PROB_ONE) ? lnt_pkg::PROB_ONE : sample.target;
          upd_q <= 1'b0;
        end
      end
      ST_FWD_TWO: acc <= $signed(mul_q[48:0]);
      ST_FWD_SUM: acc <= acc + $signed(mul_q[48:0]);
      ST_SCORE:   score_q <= score_next;
      ST_GRAD_SUM: upd_q <= batch_done;
      // Low partial product is non-negative; the rounding bit joins here.
      ST_STEP_HI:    t_q <= $signed({{(TW - 50){1'b0}}, mul_q}) + round_bit;
      ST_STEP_ADD:   t_q <= t_q + $signed({mul_q[33:0], 24'b0});
      ST_STEP_SHIFT: delta_q <= $signed(t_shift[37:0]);
      ST_DONE: begin
        if (out_free) begin
          result.probability    <= prob;
          result.decision       <= (prob >= lnt_pkg::PROB_HALF);
          result.updated        <= upd_q;
          result.weight_one_out <= first_weight;
          result.weight_two_out <= second_weight;
          result.bias_out       <= bias_term;
        end
      end
      default: ;
    endcase
  end

  assign predict_busy  = (state != ST_IDLE) && (op_q == lnt_pkg::OP_PREDICT);
  assign sums_zero     = (first_gradient_sum == '0) && (second_gradient_sum == '0) &&
                         (bias_gradient_sum == '0);
  assign learned_state = {first_weight, second_weight, bias_term, samples_in_batch};

  // Between words the open batch is always short of the largest batch size.
  `LNT_ASSERT_IMPLY(a_idle_batch_open, clk, rst, state == ST_IDLE, samples_in_batch < BATCH_CAP)
  // A closed batch leaves all gradient sums cleared.
  `LNT_ASSERT_IMPLY(a_sums_cleared, clk, rst, state == ST_DONE && upd_q, sums_zero)
  // A prediction word never touches learned state.
  `LNT_ASSERT_NEXT(a_predict_keeps_state, clk, rst, predict_busy, $stable(learned_state))
  // A new result word only comes out of the final sequencer state.
  `LNT_ASSERT_IMPLY(a_result_from_done, clk, rst, $rose(result_valid), $past(state) == ST_DONE)

endmodule

`default_nettype wire
